// ===== rtl/core/dual_key_press_debouncer_assert.svh =====
`ifndef DUAL_KEY_PRESS_DEBOUNCER_ASSERT_SVH
`define DUAL_KEY_PRESS_DEBOUNCER_ASSERT_SVH

// property checked at every edge outside reset
`define DKPD_ASSERT(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);

// property checked at every edge, reset included
`define DKPD_ASSERT_ALL(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/dkpd_pkg.sv =====
package dkpd_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int EVT_W  = 2;
  localparam int IDX_W  = 1;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [EVT_W-1:0]  evt_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam evt_t EVT_NONE = 2'd0;
  localparam evt_t EVT_KEY0 = 2'd1;
  localparam evt_t EVT_KEY1 = 2'd2;

  localparam idx_t CFG_DEBOUNCE = 1'd0;
  localparam idx_t CFG_SCAN     = 1'd1;

  localparam cfg_t DEBOUNCE_RESET = 16'd20;
  localparam cfg_t SCAN_RESET     = 16'd5;

  localparam logic LEVEL_RELEASED = 1'b1;

endpackage

// ===== rtl/core/dual_key_press_debouncer.sv =====
// a scan word enters the input register, then its result word the output register
// throughput: one scan word per cycle while out_stall is low, set by the register pair
// in_stall rises only while a word waits in the input register behind a stalled result
// reset: synchronous, clears both registers' valid flags, key states to released,
// edge and last scan times to zero, debounce_time to 20 and scan_interval to 5
module dual_key_press_debouncer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dkpd_pkg::time_t now_ms,
  input  logic            raw_light,
  input  logic            raw_feed,
  output logic            out_valid,
  input  logic            out_stall,
  output dkpd_pkg::evt_t  event_res,
  input  logic            cfg_write,
  input  dkpd_pkg::idx_t  cfg_index,
  input  dkpd_pkg::cfg_t  cfg_data
);
  import dkpd_pkg::*;

  cfg_t  debounce_time;
  cfg_t  scan_interval;

  logic  s1_valid;
  time_t s1_now;
  logic  s1_raw_light;
  logic  s1_raw_feed;
  time_t last_scan_time;

  logic  in_take;
  logic  advance;
  logic  scan_ok;
  logic  accept_scan;
  logic  press0;
  logic  press1;
  evt_t  evt;

  assign advance     = s1_valid && (!out_valid || !out_stall);
  assign in_stall    = s1_valid && out_valid && out_stall;
  assign in_take     = in_valid && !in_stall;
  assign scan_ok     = (s1_now - last_scan_time) >= {{(TIME_W-CFG_W){1'b0}}, scan_interval};
  assign accept_scan = advance && scan_ok;

  dkpd_key u_key0 (
    .clk      (clk),
    .rst      (rst),
    .en       (accept_scan),
    .raw      (s1_raw_light),
    .now      (s1_now),
    .debounce (debounce_time),
    .press    (press0)
  );

  // key 1 is left alone when key 0 reports
  dkpd_key u_key1 (
    .clk      (clk),
    .rst      (rst),
    .en       (accept_scan && !press0),
    .raw      (s1_raw_feed),
    .now      (s1_now),
    .debounce (debounce_time),
    .press    (press1)
  );

  always_comb begin
    evt = EVT_NONE;
    if (accept_scan) begin
      if (press0) begin
        evt = EVT_KEY0;
      end else if (press1) begin
        evt = EVT_KEY1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET;
      scan_interval <= SCAN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_time <= cfg_data;
        CFG_SCAN:     scan_interval <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now       <= now_ms;
      s1_raw_light <= raw_light;
      s1_raw_feed  <= raw_feed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_scan_time <= '0;
    end else if (accept_scan) begin
      last_scan_time <= s1_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res <= evt;
    end
  end

endmodule

// ===== rtl/core/dkpd_key.sv =====
module dkpd_key (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           raw,
  input  dkpd_pkg::time_t now,
  input  dkpd_pkg::cfg_t  debounce,
  output logic           press
);
  import dkpd_pkg::*;

  logic  stable;
  logic  prev;
  time_t edge_time;
  time_t elapsed;
  logic  changed;
  logic  adopt;

  assign elapsed = now - edge_time;
  assign changed = raw != prev;
  assign adopt   = !changed && (raw != stable) &&
                   (elapsed >= {{(TIME_W-CFG_W){1'b0}}, debounce});
  // released to pressed only
  assign press   = adopt && !raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable    <= LEVEL_RELEASED;
      prev      <= LEVEL_RELEASED;
      edge_time <= '0;
    end else if (en) begin
      if (changed) begin
        prev      <= raw;
        edge_time <= now;
      end else if (adopt) begin
        stable <= raw;
      end
    end
  end

endmodule

// ===== rtl/core/dkpd_checker.sv =====
`include "dual_key_press_debouncer_assert.svh"

module dkpd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input dkpd_pkg::time_t now_ms,
  input logic            raw_light,
  input logic            raw_feed,
  input logic            out_valid,
  input logic            out_stall,
  input dkpd_pkg::evt_t  event_res,
  input logic            cfg_write,
  input dkpd_pkg::idx_t  cfg_index,
  input dkpd_pkg::cfg_t  cfg_data
);
  import dkpd_pkg::*;

  // no result word is left over after reset
  `DKPD_ASSERT_ALL(a_reset_clears, clk, rst |=> !out_valid, "result valid after reset")

  // only the three event codes ever leave the block
  `DKPD_ASSERT(a_evt_code, clk, rst, out_valid |-> (event_res == EVT_NONE || event_res == EVT_KEY0 || event_res == EVT_KEY1), "bad event code")

  // a new result follows a taken scan word that passed through the input register
  `DKPD_ASSERT(a_no_invent, clk, rst, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without scan word")

  // stalled result holds
  `DKPD_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(event_res), "stalled result changed")

endmodule

bind dual_key_press_debouncer dkpd_checker u_checker (.*);

// ===== tb/sv/testbench.sv =====
module testbench;
  import dkpd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 80;

  class press_scoreboard;
    cfg_t debounce_ms;
    cfg_t interval_ms;
    logic stable_lvl[2];
    logic last_raw[2];
    time_t edge_at[2];
    time_t last_scan;
    evt_t expected_events[$];
    int errors;

    function new();
      debounce_ms = DEBOUNCE_RESET;
      interval_ms = SCAN_RESET;
      for (int k = 0; k < 2; k++) begin
        stable_lvl[k] = LEVEL_RELEASED;
        last_raw[k] = LEVEL_RELEASED;
        edge_at[k] = '0;
      end
      last_scan = '0;
      errors = 0;
    endfunction

    function void write_reg(idx_t idx, cfg_t data);
      if (idx == CFG_DEBOUNCE) begin
        debounce_ms = data;
      end else if (idx == CFG_SCAN) begin
        interval_ms = data;
      end
    endfunction

    // true when key k settles from released to pressed
    function bit key_pressed(int k, logic raw, time_t now);
      time_t held;
      logic was;
      held = now - edge_at[k];
      if (raw != last_raw[k]) begin
        last_raw[k] = raw;
        edge_at[k] = now;
        return 1'b0;
      end
      if (raw != stable_lvl[k] && held >= debounce_ms) begin
        was = stable_lvl[k];
        stable_lvl[k] = raw;
        return was == LEVEL_RELEASED && raw != LEVEL_RELEASED;
      end
      return 1'b0;
    endfunction

    function void note_scan(time_t now, logic r0, logic r1);
      evt_t evt;
      time_t gap;
      evt = EVT_NONE;
      gap = now - last_scan;
      if (gap >= interval_ms) begin
        last_scan = now;
        if (key_pressed(0, r0, now)) begin
          evt = EVT_KEY0;
        end else if (key_pressed(1, r1, now)) begin
          evt = EVT_KEY1;
        end
      end
      expected_events.push_back(evt);
    endfunction

    function void check_word(evt_t got);
      evt_t want;
      if (expected_events.size() == 0) begin
        $error("event_res: expected no word, actual %0d", got);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      if (got !== want) begin
        $error("event_res: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  time_t now_ms;
  logic raw_light;
  logic raw_feed;
  logic out_valid;
  logic out_stall;
  evt_t event_res;
  logic cfg_write;
  idx_t cfg_index;
  cfg_t cfg_data;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int quiet_cycles;
  press_scoreboard press_sb;

  dual_key_press_debouncer i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_ms(now_ms),
    .raw_light(raw_light),
    .raw_feed(raw_feed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      press_sb.check_word(event_res);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_scan(time_t t, logic r0, logic r1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    raw_light <= r0;
    raw_feed <= r1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    press_sb.note_scan(t, r0, r1);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (press_sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_timing(cfg_t deb, cfg_t intv);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data <= deb;
    @(negedge clk);
    press_sb.write_reg(CFG_DEBOUNCE, deb);
    cfg_index <= CFG_SCAN;
    cfg_data <= intv;
    @(negedge clk);
    press_sb.write_reg(CFG_SCAN, intv);
    cfg_write <= 1'b0;
  endtask

  // keys follow a slowly changing intended level with bounce and occasional random jumps, time steps scaled to settings
  task automatic random_keys(int count, bit squeeze);
    time_t t;
    logic want0;
    logic want1;
    logic r0;
    logic r1;
    int unsigned span;
    span = 32'((press_sb.debounce_ms > press_sb.interval_ms) ? press_sb.debounce_ms
                                                              : press_sb.interval_ms);
    t = $urandom;
    want0 = LEVEL_RELEASED;
    want1 = LEVEL_RELEASED;
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == 20) hold_req = 1'b1;
      if ($urandom_range(99) < 8) begin
        t = $urandom;
        r0 = 1'($urandom_range(1));
        r1 = 1'($urandom_range(1));
      end else begin
        t += $urandom_range(span / 2 + 3);
        if ($urandom_range(7) == 0) want0 = ~want0;
        if ($urandom_range(7) == 0) want1 = ~want1;
        r0 = ($urandom_range(99) < 12) ? ~want0 : want0;
        r1 = ($urandom_range(99) < 12) ? ~want1 : want1;
      end
      send_scan(t, r0, r1);
    end
  endtask

  initial begin
    cfg_t deb;
    cfg_t intv;
    rst = 1'b1;
    in_valid = 1'b0;
    now_ms = '0;
    raw_light = LEVEL_RELEASED;
    raw_feed = LEVEL_RELEASED;
    cfg_write = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_data = '0;
    send_idle_pct = 29;
    recv_idle_pct = 29;
    hold_req = 1'b0;
    press_sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset timing: throttling, debounce, priority, release, wrap, going backwards
    send_scan(32'd0, 1'b1, 1'b1);
    send_scan(32'd5, 1'b0, 1'b1);
    send_scan(32'd10, 1'b0, 1'b1);
    send_scan(32'd25, 1'b0, 1'b1);
    send_scan(32'd27, 1'b1, 1'b1);
    send_scan(32'd30, 1'b0, 1'b0);
    send_scan(32'd50, 1'b0, 1'b0);
    send_scan(32'd60, 1'b1, 1'b1);
    send_scan(32'd80, 1'b1, 1'b1);
    send_scan(32'd90, 1'b0, 1'b0);
    send_scan(32'd110, 1'b0, 1'b0);
    send_scan(32'd115, 1'b0, 1'b0);
    send_scan(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_scan(32'h0000_0013, 1'b1, 1'b1);
    send_scan(32'h0000_0010, 1'b0, 1'b1);

    // zero intervals
    set_timing(16'h0000, 16'h0000);
    send_scan(32'h0000_0010, 1'b0, 1'b0);
    send_scan(32'h0000_0010, 1'b0, 1'b0);
    send_scan(32'h0000_0010, 1'b0, 1'b0);

    // widest intervals
    set_timing(16'hFFFF, 16'hFFFF);
    send_scan(32'h0001_0010, 1'b1, 1'b1);
    send_scan(32'h0002_000F, 1'b1, 1'b1);
    send_scan(32'h0002_00FF, 1'b0, 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          deb = 16'h0000;
          intv = 16'h0000;
        end
        1: begin
          deb = 16'hFFFF;
          intv = 16'hFFFF;
        end
        2: begin
          deb = 16'hFFFF;
          intv = 16'h0000;
        end
        3: begin
          deb = 16'h0000;
          intv = 16'hFFFF;
        end
        4: begin
          deb = DEBOUNCE_RESET;
          intv = SCAN_RESET;
        end
        default: begin
          deb = cfg_t'($urandom_range(64));
          intv = cfg_t'($urandom_range(16));
        end
      endcase
      send_idle_pct = (p == 2) ? 0 : 29;
      recv_idle_pct = (p == 2) ? 0 : 29;
      set_timing(deb, intv);
      random_keys(150, p == 5);
    end

    drain();
    repeat (2) @(negedge clk);
    if (press_sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
